@@ hw/rtl/shared_pool_multi_queue_fifo_assert.svh @@
// Assertion macros for the shared pool queue manager.
// Define ASSERT_OFF to compile the checks out.
`ifndef SHARED_POOL_MULTI_QUEUE_FIFO_ASSERT_SVH
`define SHARED_POOL_MULTI_QUEUE_FIFO_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SPMQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq: assertion failed");
// Next-cycle implication.
`define SPMQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq: assertion failed");
`else
`define SPMQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPMQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/spmq_pkg.sv @@
package spmq_pkg;

   localparam int QID_BITS       = 2;
   localparam int SIZE_BITS      = 32;
   localparam int CAP_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STATUS_BITS    = 3;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 8'd128;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK          = 3'd0,
      ST_NULL        = 3'd1,
      ST_FULL        = 3'd2,
      ST_POOL_EMPTY  = 3'd3,
      ST_QUEUE_EMPTY = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic init_step;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic init_last;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ hw/rtl/spmq_ram.sv @@
module spmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/spmq_ctrl.sv @@
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  spmq_pkg::dp_status_type status,
   output spmq_pkg::ctrl_cmd_type  cmd,
   output logic                   ready
);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               if (status.init_last) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_COMMIT;
                  ready_ff <= 1'b0;
               end
            end
            S_COMMIT: begin
               if (status.rsp_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_INIT;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign cmd.init_step = (state_ff == S_INIT);
   assign cmd.accept    = ready_ff & req_valid;
   assign cmd.commit    = (state_ff == S_COMMIT) & status.rsp_free;
   assign ready         = ready_ff;

endmodule

@@ hw/rtl/spmq_dp.sv @@
module spmq_dp #(
   parameter int POOL_SLOTS  = 128,
   parameter int NUM_QUEUES  = 4,
   parameter int HANDLE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  spmq_pkg::ctrl_cmd_type                  cmd,
   output spmq_pkg::dp_status_type                 status,
   input  logic                                    req_action,
   input  logic [spmq_pkg::QID_BITS-1:0]           req_queue_id,
   input  logic [HANDLE_BITS-1:0]                  req_data_handle,
   input  logic [spmq_pkg::SIZE_BITS-1:0]          req_data_size,
   input  logic                                    csr_write,
   input  logic [spmq_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [spmq_pkg::CAP_BITS-1:0]           csr_data,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output logic [spmq_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [HANDLE_BITS-1:0]                  rsp_out_handle,
   output logic [spmq_pkg::SIZE_BITS-1:0]          rsp_out_size
);

   localparam int SW   = $clog2(POOL_SLOTS);
   localparam int UW   = $clog2(POOL_SLOTS + 1);
   localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CMPW = (UW > spmq_pkg::CAP_BITS) ? UW : spmq_pkg::CAP_BITS;
   localparam int DW   = HANDLE_BITS + spmq_pkg::SIZE_BITS;

   // queue and pool bookkeeping
   logic [SW-1:0]                 head_ff  [NUM_QUEUES];
   logic [SW-1:0]                 head_in  [NUM_QUEUES];
   logic [SW-1:0]                 tail_ff  [NUM_QUEUES];
   logic [SW-1:0]                 tail_in  [NUM_QUEUES];
   logic [UW-1:0]                 usage_ff [NUM_QUEUES];
   logic [UW-1:0]                 usage_in [NUM_QUEUES];
   logic [spmq_pkg::CAP_BITS-1:0] capacity_ff [NUM_QUEUES];
   logic [spmq_pkg::CAP_BITS-1:0] capacity_in [NUM_QUEUES];
   logic [SW-1:0]                 free_head_ff, free_head_in;
   logic [UW-1:0]                 free_count_ff, free_count_in;
   logic [SW-1:0]                 init_cnt_ff, init_cnt_in;

   // request held across the memory read
   logic                          action_ff, action_in;
   logic [QW-1:0]                 q_ff, q_in;
   logic [HANDLE_BITS-1:0]        handle_ff, handle_in;
   logic [spmq_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic [SW-1:0]                 slot_ff, slot_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spmq_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0]          rsp_handle_ff, rsp_handle_in;
   logic [spmq_pkg::SIZE_BITS-1:0]  rsp_size_ff, rsp_size_in;

   logic [2:0]                    q_wrap;
   logic [QW-1:0]                 q_req;
   logic                          link_we, data_we;
   logic [SW-1:0]                 link_waddr, link_wdata, link_raddr, link_rdata;
   logic [SW-1:0]                 data_waddr;
   logic [DW-1:0]                 data_wdata, data_rdata;
   logic [UW-1:0]                 usage_q;
   logic [spmq_pkg::CAP_BITS-1:0] cap_q;
   spmq_pkg::status_type          st;
   logic                          push_ok, pop_ok, do_push, do_pop;

   // queue number modulo NUM_QUEUES: at most three subtractions on a 3-bit value
   always_comb begin
      q_wrap = {1'b0, req_queue_id};
      for (int k = 0; k < 3; k++) begin
         if (int'(q_wrap) >= NUM_QUEUES) begin
            q_wrap = q_wrap - 3'(NUM_QUEUES);
         end
      end
      q_req = q_wrap[QW-1:0];
   end

   assign usage_q = usage_ff[q_ff];
   assign cap_q   = capacity_ff[q_ff];

   always_comb begin
      st      = spmq_pkg::ST_OK;
      push_ok = 1'b0;
      pop_ok  = 1'b0;
      if (action_ff == spmq_pkg::ACT_PUSH) begin
         if (handle_ff == '0) begin
            st = spmq_pkg::ST_NULL;
         end else if (CMPW'(usage_q) >= CMPW'(cap_q)) begin
            st = spmq_pkg::ST_FULL;
         end else if (free_count_ff == '0) begin
            st = spmq_pkg::ST_POOL_EMPTY;
         end else begin
            push_ok = 1'b1;
         end
      end else begin
         if (usage_q == '0) begin
            st = spmq_pkg::ST_QUEUE_EMPTY;
         end else begin
            pop_ok = 1'b1;
         end
      end
   end

   assign do_push = cmd.commit & push_ok;
   assign do_pop  = cmd.commit & pop_ok;

   // memory ports: reads only at accept, writes only at commit or init
   assign link_raddr = (req_action == spmq_pkg::ACT_POP) ? head_ff[q_req] : free_head_ff;

   always_comb begin
      link_we    = 1'b0;
      link_waddr = init_cnt_ff;
      link_wdata = free_head_ff;
      if (cmd.init_step) begin
         link_we    = 1'b1;
         link_wdata = status.init_last ? '0 : init_cnt_ff + 1'b1;
      end else if (do_push && (usage_q != '0)) begin
         link_we    = 1'b1;
         link_waddr = tail_ff[q_ff];
      end else if (do_pop) begin
         link_we    = 1'b1;
         link_waddr = slot_ff;
      end
   end

   assign data_we    = do_push;
   assign data_waddr = free_head_ff;
   assign data_wdata = {handle_ff, size_ff};

   spmq_ram #(
      .WIDTH (SW),
      .DEPTH (POOL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   spmq_ram #(
      .WIDTH (DW),
      .DEPTH (POOL_SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (head_ff[q_req]),
      .rd_data (data_rdata)
   );

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      usage_in      = usage_ff;
      capacity_in   = capacity_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      init_cnt_in   = init_cnt_ff;
      action_in     = action_ff;
      q_in          = q_ff;
      handle_in     = handle_ff;
      size_in       = size_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_size_in   = rsp_size_ff;

      if (cmd.init_step) begin
         init_cnt_in = init_cnt_ff + 1'b1;
      end

      for (int k = 0; k < NUM_QUEUES; k++) begin
         if (csr_write && (int'(csr_index) == k)) begin
            capacity_in[k] = csr_data;
         end
      end

      if (cmd.accept) begin
         action_in = req_action;
         q_in      = q_req;
         handle_in = req_data_handle;
         size_in   = req_data_size;
         slot_in   = head_ff[q_req];
      end

      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st;
         rsp_handle_in = pop_ok ? data_rdata[DW-1:spmq_pkg::SIZE_BITS] : '0;
         rsp_size_in   = pop_ok ? data_rdata[spmq_pkg::SIZE_BITS-1:0] : '0;
      end

      if (do_push) begin
         free_head_in  = link_rdata;
         free_count_in = free_count_ff - 1'b1;
         if (usage_q == '0) begin
            head_in[q_ff] = free_head_ff;
         end
         tail_in[q_ff]  = free_head_ff;
         usage_in[q_ff] = usage_q + 1'b1;
      end

      if (do_pop) begin
         head_in[q_ff]  = link_rdata;
         usage_in[q_ff] = usage_q - 1'b1;
         free_head_in   = slot_ff;
         if (free_count_ff != UW'(POOL_SLOTS)) begin
            free_count_in = free_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_QUEUES; k++) begin
            head_ff[k]     <= '0;
            tail_ff[k]     <= '0;
            usage_ff[k]    <= '0;
            capacity_ff[k] <= spmq_pkg::CAPACITY_RESET;
         end
         free_head_ff  <= '0;
         free_count_ff <= UW'(POOL_SLOTS);
         init_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         usage_ff      <= usage_in;
         capacity_ff   <= capacity_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         init_cnt_ff   <= init_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      q_ff          <= q_in;
      handle_ff     <= handle_in;
      size_ff       <= size_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign status.init_last = (init_cnt_ff == SW'(POOL_SLOTS - 1));
   assign status.rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_size   = rsp_size_ff;

endmodule

@@ hw/rtl/shared_pool_multi_queue_fifo.sv @@
// Channel   Direction  Handshake            Carries
// req_      in         req_valid/req_stall  action, queue_id, data_handle, data_size
// rsp_      out        rsp_valid/rsp_stall  status, out_handle, out_size
// csr_      in         csr_write            capacity of queue csr_index
//
// Each request takes an accept step (link and data memory read issued), then commit
// (checks, link write-back, result registered). The registered read of the link
// memory is needed before its write-back.
// After reset a sweep over all POOL_SLOTS slots chains the free list in slot order;
// req_stall stays high meanwhile. Capacity writes are taken throughout.
// A stalled result holds commit back; one further request may be taken meanwhile
// and its commit waits until the result leaves.
`include "shared_pool_multi_queue_fifo_assert.svh"

module shared_pool_multi_queue_fifo #(
   parameter int POOL_SLOTS  = 128,
   parameter int NUM_QUEUES  = 4,
   parameter int HANDLE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [spmq_pkg::QID_BITS-1:0]       req_queue_id,
   input  logic [HANDLE_BITS-1:0]              req_data_handle,
   input  logic [spmq_pkg::SIZE_BITS-1:0]      req_data_size,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spmq_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0]              rsp_out_handle,
   output logic [spmq_pkg::SIZE_BITS-1:0]      rsp_out_size,
   // capacity registers
   input  logic                                csr_write,
   input  logic [spmq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spmq_pkg::CAP_BITS-1:0]       csr_data
);

   spmq_pkg::ctrl_cmd_type  cmd;
   spmq_pkg::dp_status_type status;
   logic                    ready;

   // sequencer: init sweep, idle, commit
   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .ready     (ready)
   );

   // pointers, counters, slot memories and the result register
   spmq_dp #(
      .POOL_SLOTS  (POOL_SLOTS),
      .NUM_QUEUES  (NUM_QUEUES),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_queue_id    (req_queue_id),
      .req_data_handle (req_data_handle),
      .req_data_size   (req_data_size),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_out_size    (rsp_out_size)
   );

   assign req_stall = ~ready;

   // an accepted request blocks the channel for the following cycle
   `SPMQ_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // every commit leaves a result on the output
   `SPMQ_ASSERT_NXT(a_commit_gives_rsp, clock, reset, cmd.commit, rsp_valid)
   // nothing is taken during the free-list sweep
   `SPMQ_ASSERT_IMP(a_init_stalls, clock, reset, cmd.init_step, req_stall)
   // sweep, accept and commit never overlap
   `SPMQ_ASSERT_IMP(a_cmd_exclusive, clock, reset, 1'b1,
                    $onehot0({cmd.init_step, cmd.accept, cmd.commit}))

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int POOL_SLOTS    = 128;
   localparam int NUM_QUEUES    = 4;
   localparam int HANDLE_BITS   = 32;
   // Slack after the last answer for the final request and the result register.
   localparam int SETTLE_CYCLES = 8;
   // Long enough that the block fills up and holds off the request side.
   localparam int HOLD_CYCLES   = 300;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic                             action;
      logic [spmq_pkg::QID_BITS-1:0]    qid;
      logic [HANDLE_BITS-1:0]           handle;
      logic [spmq_pkg::SIZE_BITS-1:0]   size;
   } request_type;

   typedef struct packed {
      spmq_pkg::status_type             status;
      logic [HANDLE_BITS-1:0]           handle;
      logic [spmq_pkg::SIZE_BITS-1:0]   size;
   } answer_type;

   // One directed row: a request, and where obvious the answer typed in.
   typedef struct packed {
      logic        is_typed;
      request_type req;
      answer_type  ans;
   } stim_row_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_action = spmq_pkg::ACT_PUSH;
   logic [spmq_pkg::QID_BITS-1:0]       req_queue_id = '0;
   logic [HANDLE_BITS-1:0]              req_data_handle = '0;
   logic [spmq_pkg::SIZE_BITS-1:0]      req_data_size = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [spmq_pkg::STATUS_BITS-1:0]    rsp_status;
   logic [HANDLE_BITS-1:0]              rsp_out_handle;
   logic [spmq_pkg::SIZE_BITS-1:0]      rsp_out_size;
   logic                                csr_write = 1'b0;
   logic [spmq_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [spmq_pkg::CAP_BITS-1:0]       csr_data = '0;

   // --- predictor state: slot pool, free list and per-queue chains ---
   logic [6:0]                     slot_next [POOL_SLOTS];
   logic [HANDLE_BITS-1:0]         slot_hdl  [POOL_SLOTS];
   logic [spmq_pkg::SIZE_BITS-1:0] slot_len  [POOL_SLOTS];
   logic [6:0]                     free_first;
   logic [7:0]                     free_left;
   logic [6:0]                     q_first [NUM_QUEUES];
   logic [6:0]                     q_last  [NUM_QUEUES];
   logic [7:0]                     q_fill  [NUM_QUEUES];
   logic [spmq_pkg::CAP_BITS-1:0]  q_cap   [NUM_QUEUES];

   // answers owed by the block, oldest first
   answer_type owed_answers [$];
   int         failures = 0;

   // idling knobs, set per phase by the main sequence
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int holds_asked        = 0;
   int holds_done         = 0;
   int hold_left          = 0;

   // Directed part. Empty-queue pops, null pushes, zero and unit capacity,
   // all-ones and all-zero fields, pops carrying junk handle/size fields.
   // Capacities during this part: q0 128, q1 255, q2 0, q3 1.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd1, 32'h0000_0000, 32'h0000_0000},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd2, 32'h1234_5678, 32'h0000_0001},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd3, 32'hFFFF_FFFF, 32'h0000_0000},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF},
              '{spmq_pkg::ST_NULL, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd2, 32'h0000_0001, 32'h0000_0005},
              '{spmq_pkg::ST_FULL, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd2, 32'h0000_0000, 32'h0000_0005},
              '{spmq_pkg::ST_NULL, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              '{spmq_pkg::ST_OK, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd0, 32'h0000_0001, 32'h0000_0000},
              '{spmq_pkg::ST_OK, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd3, 32'h5A5A_5A5A, 32'hA5A5_A5A5},
              '{spmq_pkg::ST_OK, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd3, 32'h0000_0002, 32'h0000_0002},
              '{spmq_pkg::ST_FULL, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_PUSH, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF},
              '{spmq_pkg::ST_OK, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd0, 32'h0000_0000, 32'h0000_0000},
              '{spmq_pkg::ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd3, 32'hDEAD_BEEF, 32'hCAFE_F00D},
              '{spmq_pkg::ST_OK, 32'h5A5A_5A5A, 32'hA5A5_A5A5}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd3, 32'h0000_0000, 32'h0000_0000},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b0, '{spmq_pkg::ACT_PUSH, 2'd3, 32'h0000_0003, 32'h0000_0003}, '0},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              '{spmq_pkg::ST_OK, 32'h0000_0001, 32'h0000_0000}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd0, 32'h0000_0000, 32'h0000_0000},
              '{spmq_pkg::ST_QUEUE_EMPTY, 32'h0, 32'h0}},
      '{1'b1, '{spmq_pkg::ACT_POP,  2'd1, 32'h0000_0000, 32'h0000_0000},
              '{spmq_pkg::ST_OK, 32'h8000_0000, 32'h7FFF_FFFF}},
      '{1'b0, '{spmq_pkg::ACT_PUSH, 2'd0, 32'h0000_0007, 32'h0000_0009}, '0},
      '{1'b0, '{spmq_pkg::ACT_PUSH, 2'd1, 32'h0000_0008, 32'h0000_000A}, '0},
      '{1'b0, '{spmq_pkg::ACT_POP,  2'd3, 32'h0000_0000, 32'h0000_0000}, '0},
      '{1'b0, '{spmq_pkg::ACT_POP,  2'd1, 32'hFFFF_FFFF, 32'h0000_0000}, '0},
      '{1'b0, '{spmq_pkg::ACT_POP,  2'd0, 32'h0000_0000, 32'hFFFF_FFFF}, '0}
   };

   shared_pool_multi_queue_fifo #(
      .POOL_SLOTS  (POOL_SLOTS),
      .NUM_QUEUES  (NUM_QUEUES),
      .HANDLE_BITS (HANDLE_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_queue_id    (req_queue_id),
      .req_data_handle (req_data_handle),
      .req_data_size   (req_data_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_out_size    (rsp_out_size),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, well beyond the slowest legal run.
   initial begin
      #2ms;
      $display("tb: FAIL");
      $finish;
   end

   // Works out the answer to one accepted request and moves the predicted
   // pool along. Push checks: null handle, then queue full, then pool
   // empty; pop only checks for an empty queue. Rejects leave state alone.
   function automatic answer_type serve_request(input request_type r);
      answer_type a;
      logic [6:0] s;
      int         q;
      a = '0;
      a.status = spmq_pkg::ST_OK;
      q = int'(r.qid);
      if (r.action == spmq_pkg::ACT_PUSH) begin
         if (r.handle == '0) begin
            a.status = spmq_pkg::ST_NULL;
         end else if (q_fill[q] >= q_cap[q]) begin
            a.status = spmq_pkg::ST_FULL;
         end else if (free_left == 0) begin
            a.status = spmq_pkg::ST_POOL_EMPTY;
         end else begin
            s = free_first;
            free_first = slot_next[s];
            free_left--;
            slot_hdl[s] = r.handle;
            slot_len[s] = r.size;
            if (q_fill[q] == 0)
               q_first[q] = s;
            else
               slot_next[q_last[q]] = s;
            q_last[q] = s;
            q_fill[q]++;
         end
      end else begin
         if (q_fill[q] == 0) begin
            a.status = spmq_pkg::ST_QUEUE_EMPTY;
         end else begin
            // unlink the head and return its slot to the front of the free list
            s = q_first[q];
            a.handle = slot_hdl[s];
            a.size = slot_len[s];
            q_first[q] = slot_next[s];
            q_fill[q]--;
            slot_next[s] = free_first;
            free_first = s;
            free_left++;
         end
      end
      return a;
   endfunction

   // Random request. Most traffic goes to a focus queue so that chains get
   // long; handles are mostly non-null so pushes get past the first check.
   function automatic request_type random_request(input int push_pct, input int focus);
      request_type r;
      r.action = ($urandom_range(99) < push_pct) ? spmq_pkg::ACT_PUSH : spmq_pkg::ACT_POP;
      r.qid = ($urandom_range(3) == 0) ? spmq_pkg::QID_BITS'($urandom_range(3))
                                       : spmq_pkg::QID_BITS'(focus);
      case ($urandom_range(15))
         0:       r.handle = '0;
         1:       r.handle = '1;
         2:       r.handle = HANDLE_BITS'(1);
         default: r.handle = HANDLE_BITS'($urandom);
      endcase
      case ($urandom_range(7))
         0:       r.size = '0;
         1:       r.size = '1;
         default: r.size = $urandom;
      endcase
      return r;
   endfunction

   // Offers one request and holds it until taken; the predictor runs at the
   // accepting edge. Valid is only dropped when an idle gap follows.
   task automatic offer(input request_type r, input logic is_typed,
                        input answer_type typed_ans);
      answer_type predicted;
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_queue_id    <= r.qid;
      req_data_handle <= r.handle;
      req_data_size   <= r.size;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      predicted = serve_request(r);
      owed_answers.push_back(is_typed ? typed_ans : predicted);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Stretches of random traffic; the focus queue is picked anew every 24 requests.
   task automatic run_traffic(input int count, input int push_pct);
      int focus;
      focus = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 24 == 0)
            focus = $urandom_range(NUM_QUEUES - 1);
         offer(random_request(push_pct, focus), 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // Sender stays quiet until every owed answer is back, then waits out
   // SETTLE_CYCLES so the block is certainly idle.
   task automatic settle();
      while (owed_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four capacity registers, one per cycle.
   task automatic set_capacities(input logic [spmq_pkg::CAP_BITS-1:0] c0, c1, c2, c3);
      logic [spmq_pkg::CAP_BITS-1:0] vals [NUM_QUEUES];
      vals = '{c0, c1, c2, c3};
      for (int i = 0; i < NUM_QUEUES; i++) begin
         csr_write <= 1'b1;
         csr_index <= spmq_pkg::CSR_INDEX_BITS'(i);
         csr_data  <= vals[i];
         q_cap[i] = vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Receiver side: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (holds_asked != holds_done) begin
         holds_done = holds_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Checks each result taken against the oldest owed answer.
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (owed_answers.size() == 0) begin
            $error("unexpected result: status %0d handle %h size %h",
                   rsp_status, rsp_out_handle, rsp_out_size);
            failures++;
         end else begin
            want = owed_answers.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_out_handle !== want.handle) begin
               $error("out_handle: expected %h, got %h", want.handle, rsp_out_handle);
               failures++;
            end
            if (rsp_out_size !== want.size) begin
               $error("out_size: expected %h, got %h", want.size, rsp_out_size);
               failures++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      // predictor after reset: free list chained in slot order, queues empty
      for (int i = 0; i < POOL_SLOTS; i++) begin
         slot_next[i] = 7'(i + 1);
         slot_hdl[i] = '0;
         slot_len[i] = '0;
      end
      free_first = '0;
      free_left = 8'(POOL_SLOTS);
      for (int i = 0; i < NUM_QUEUES; i++) begin
         q_first[i] = '0;
         q_last[i] = '0;
         q_fill[i] = '0;
         q_cap[i] = spmq_pkg::CAPACITY_RESET;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling. The free-list sweep after reset just shows
      // up as req_stall; capacity writes are taken during it.
      set_capacities(8'd128, 8'd255, 8'd0, 8'd1);
      foreach (directed_rows[i])
         offer(directed_rows[i].req, directed_rows[i].is_typed, directed_rows[i].ans);
      req_valid <= 1'b0;
      settle();

      // no idling, mid-range capacities
      set_capacities(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
                     8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
      run_traffic(150, 55);
      settle();

      // sender idle 60%, tiny capacities so queue-full turns up often
      sender_idle_pct = 60;
      set_capacities(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                     8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
      run_traffic(150, 60);
      settle();

      // receiver stalls 60%; capacities at or above the pool, push-heavy, so the
      // pool runs dry and answers pool empty
      sender_idle_pct = 0;
      receiver_stall_pct = 60;
      set_capacities(8'd255, 8'd255, 8'd255, 8'd128);
      run_traffic(220, 90);
      settle();

      // both sides idle 25%, any capacity the register holds; drains the pool
      sender_idle_pct = 25;
      receiver_stall_pct = 25;
      set_capacities(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_traffic(200, 40);
      settle();

      // long receiver hold-off while requests keep coming: block backs up
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      holds_asked++;
      run_traffic(24, 50);
      settle();

      // extremes again, both sides idling
      sender_idle_pct = 25;
      receiver_stall_pct = 25;
      set_capacities(8'd255, 8'd0, 8'd1, 8'd128);
      run_traffic(100, 55);

      settle();
      if (failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
